@@ hdl/rsmm_pkg.sv @@
// Shared constants for the ring send matrix mixer: field widths, item kinds,
// default sizes and the reset glide step. No dependencies.
package rsmm_pkg;

    localparam int BUS_COUNT_DEF  = 3;
    localparam int RING_DEPTH_DEF = 16384;

    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 24;
    localparam int TIME_W   = 48;
    localparam int STEP_W   = 23;

    localparam logic [STEP_W-1:0] GLIDE_RESET = 23'd8738;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_GAIN  = 2'd2;

    localparam int RES_DEPTH = 4;

endpackage

@@ hdl/ring_send_matrix_mixer.sv @@
// Ring send matrix mixer: per-bus sample rings in one synchronous memory,
// gliding send gains and a small result queue.
// Depends on rsmm_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one item per handshake:
//   kind 0 stores a stereo sample in the ring of its bus, kind 2 sets a
//   wanted send gain, kind 1 asks for one mixed output frame of a target bus.
//   Output channel (o_out_valid / i_out_ready) gives one frame per read item,
//   in order. Config channel (i_cfg_valid / o_cfg_ready) writes glide_step at
//   any time the block is idle; it is always ready.
//   Items: a write or set-gain item leaves the slot without holding up the
//   next one; a read item holds the ring memory's single read port while it
//   walks the other buses as sources, one source bus per cycle.
//   Path: a read frame passes ring read, multiply, accumulate and round,
//   then the queue; a frame of zeros for an out-of-range bus or zero slice
//   length takes the same path without the walk over sources.
//   Reset: gains and run times clear to zero, glide_step returns to 8738.
//   The ring memory is not cleared; entries read before being written are
//   undefined. No clearing pass, items are taken straight after reset.
//   Stall: up to RES_DEPTH frames are held while the receiver stalls; with
//   that many read items outstanding the input stops taking items.
module ring_send_matrix_mixer import rsmm_pkg::*; #(
    parameter int BUS_COUNT  = BUS_COUNT_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_kind,
    input  logic [1:0]                 i_bus,
    input  logic [1:0]                 i_peer_bus,
    input  logic [TIME_W-1:0]          i_slice_time,
    input  logic [11:0]                i_frame_index,
    input  logic [12:0]                i_slice_frames,
    input  logic signed [SAMPLE_W-1:0] i_left_in,
    input  logic signed [SAMPLE_W-1:0] i_right_in,
    input  logic signed [GAIN_W-1:0]   i_gain_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_left_out,
    output logic signed [SAMPLE_W-1:0] o_right_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [STEP_W-1:0]          i_cfg_glide_step
);

    localparam int BW        = $clog2(BUS_COUNT);
    localparam int LD        = $clog2(RING_DEPTH);
    localparam int AW        = BW + LD;
    localparam int MEM_DEPTH = BUS_COUNT * RING_DEPTH;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int ACC_W     = PROD_W + BW;
    localparam int QW        = ACC_W - 22;
    localparam int PW        = TIME_W + 2;
    localparam int RPW       = $clog2(RES_DEPTH);
    localparam int CW        = $clog2(RES_DEPTH + 1);
    localparam logic [TIME_W-1:0] VALID_SPAN = TIME_W'(RING_DEPTH / 4);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << 21);

    // configuration
    logic [STEP_W-1:0] r_glide_step;

    // item slot
    logic                       r_a_valid;
    logic [1:0]                 r_a_kind;
    logic [1:0]                 r_a_bus;
    logic [1:0]                 r_a_peer;
    logic [TIME_W-1:0]          r_a_t;
    logic [11:0]                r_a_n;
    logic [12:0]                r_a_frames;
    logic signed [SAMPLE_W-1:0] r_a_left;
    logic signed [SAMPLE_W-1:0] r_a_right;
    logic signed [GAIN_W-1:0]   r_a_gain;
    logic [PW-1:0]              r_a_p;
    logic [BW-1:0]              r_k;
    logic [PW-1:0]              n_a_p;

    // state
    logic signed [GAIN_W-1:0] r_want  [BUS_COUNT][BUS_COUNT];
    logic signed [GAIN_W-1:0] r_glide [BUS_COUNT][BUS_COUNT];
    logic [TIME_W-1:0]        r_run_start [BUS_COUNT];
    logic [TIME_W-1:0]        r_run_end   [BUS_COUNT];
    logic [2*SAMPLE_W-1:0]    r_ring [MEM_DEPTH];
    logic [2*SAMPLE_W-1:0]    r_ring_q;

    // pipeline
    logic                       r_b_valid, r_b_use, r_b_first, r_b_last;
    logic signed [GAIN_W-1:0]   r_b_g;
    logic                       r_c_valid, r_c_first, r_c_last;
    logic signed [PROD_W-1:0]   r_c_prod_l, r_c_prod_r;
    logic signed [ACC_W-1:0]    r_acc_l, r_acc_r;
    logic                       r_d_push;

    // result queue
    logic signed [SAMPLE_W-1:0] r_fifo_l [RES_DEPTH];
    logic signed [SAMPLE_W-1:0] r_fifo_r [RES_DEPTH];
    logic [RPW-1:0]             r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]              r_fill, r_cred;

    logic                    in_acc, out_pop;
    logic                    a_bus_ok, a_peer_ok, a_frames_ok;
    logic                    a_is_read, a_zero_read, a_iter, a_last, a_use;
    logic                    a_wr, a_set;
    logic [BW-1:0]           a_bidx, a_pidx, a_src, a_run_idx;
    logic [TIME_W-1:0]       run_start_q, run_end_q, end_diff;
    logic signed [GAIN_W-1:0] want_q, g_q, g_new;
    logic signed [GAIN_W+1:0] step_x, want_x, g_up, g_dn, g_new_x;
    logic                    gain_skip, src_valid, p_ok;
    logic [AW-1:0]           w_addr, r_addr;
    logic [LD-1:0]           w_idx;
    logic signed [ACC_W-1:0] rnd_l, rnd_r;
    logic signed [QW-1:0]    q_l, q_r;
    logic signed [SAMPLE_W-1:0] sat_l, sat_r;

    function automatic logic signed [SAMPLE_W-1:0] sat_q23(input logic signed [QW-1:0] q);
        logic fits;
        fits = (&q[QW-1:SAMPLE_W-1]) || ~(|q[QW-1:SAMPLE_W-1]);
        if (fits) begin
            return q[SAMPLE_W-1:0];
        end else if (q[QW-1]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign out_pop     = o_out_valid && i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (!r_a_valid || a_last) && (r_cred < CW'(RES_DEPTH));
    assign n_a_p       = PW'(i_slice_time) - PW'(i_slice_frames) + PW'(i_frame_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glide_step <= GLIDE_RESET;
        end else if (i_cfg_valid) begin
            r_glide_step <= i_cfg_glide_step;
        end
    end

    // item slot control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_k       <= '0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
            r_k       <= '0;
        end else if (r_a_valid) begin
            if (a_last) begin
                r_a_valid <= 1'b0;
            end else begin
                r_k <= r_k + BW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_kind   <= i_kind;
            r_a_bus    <= i_bus;
            r_a_peer   <= i_peer_bus;
            r_a_t      <= i_slice_time;
            r_a_n      <= i_frame_index;
            r_a_frames <= i_slice_frames;
            r_a_left   <= i_left_in;
            r_a_right  <= i_right_in;
            r_a_gain   <= i_gain_in;
            r_a_p      <= n_a_p;
        end
    end

    // decode and per-source work
    always_comb begin
        a_bus_ok    = ({30'd0, r_a_bus} < 32'(BUS_COUNT));
        a_peer_ok   = ({30'd0, r_a_peer} < 32'(BUS_COUNT));
        a_frames_ok = (r_a_frames != '0);
        a_bidx      = BW'(r_a_bus);
        a_pidx      = BW'(r_a_peer);
        a_is_read   = r_a_valid && (r_a_kind == KIND_READ);
        a_zero_read = !(a_bus_ok && a_frames_ok);
        a_iter      = a_is_read && !a_zero_read;
        a_last      = !a_is_read || a_zero_read || (r_k == BW'(BUS_COUNT - 2));
        a_src       = (r_k >= a_bidx) ? r_k + BW'(1) : r_k;
        a_wr        = r_a_valid && (r_a_kind == KIND_WRITE) && a_bus_ok && a_frames_ok;
        a_set       = r_a_valid && (r_a_kind == KIND_GAIN) && a_bus_ok && a_peer_ok;
        a_run_idx   = a_is_read ? a_src : a_bidx;
        run_start_q = r_run_start[a_run_idx];
        run_end_q   = r_run_end[a_run_idx];

        want_q    = r_want[a_src][a_bidx];
        g_q       = r_glide[a_src][a_bidx];
        gain_skip = (want_q == '0) && (g_q == '0);
        step_x    = $signed({3'b000, r_glide_step});
        want_x    = {{2{want_q[GAIN_W-1]}}, want_q};
        g_up      = {{2{g_q[GAIN_W-1]}}, g_q} + step_x;
        g_dn      = {{2{g_q[GAIN_W-1]}}, g_q} - step_x;
        if (g_q < want_q) begin
            g_new_x = (g_up > want_x) ? want_x : g_up;
        end else begin
            g_new_x = (g_dn < want_x) ? want_x : g_dn;
        end
        g_new = g_new_x[GAIN_W-1:0];

        end_diff  = run_end_q - r_a_t;
        src_valid = (run_end_q >= r_a_t) && (end_diff <= VALID_SPAN);
        p_ok      = !r_a_p[PW-1] && (r_a_p[PW-2:0] >= {1'b0, run_start_q});
        a_use     = a_iter && !gain_skip && src_valid && p_ok;

        w_idx  = r_a_t[LD-1:0] + LD'(r_a_n);
        w_addr = {a_bidx, w_idx};
        r_addr = {a_src, r_a_p[LD-1:0]};
    end

    // gains and run times
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < BUS_COUNT; s++) begin
                r_run_start[s] <= '0;
                r_run_end[s]   <= '0;
                for (int d = 0; d < BUS_COUNT; d++) begin
                    r_want[s][d]  <= '0;
                    r_glide[s][d] <= '0;
                end
            end
        end else begin
            if (a_set) begin
                r_want[a_bidx][a_pidx] <= (a_bidx == a_pidx) ? '0 : r_a_gain;
            end
            if (a_iter && !gain_skip) begin
                r_glide[a_src][a_bidx] <= g_new;
            end
            if (a_wr) begin
                if ((r_a_n == '0) && (r_a_t != run_end_q)) begin
                    r_run_start[a_bidx] <= r_a_t;
                end
                r_run_end[a_bidx] <= r_a_t + TIME_W'(r_a_frames);
            end
        end
    end

    // sample rings
    always_ff @(posedge i_clk) begin
        if (a_wr) begin
            r_ring[w_addr] <= {r_a_left, r_a_right};
        end
        if (a_use) begin
            r_ring_q <= r_ring[r_addr];
        end
    end

    // weight, accumulate, round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_push  <= 1'b0;
        end else begin
            r_b_valid <= a_is_read;
            r_c_valid <= r_b_valid;
            r_d_push  <= r_c_valid && r_c_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_use   <= a_use;
        r_b_g     <= g_new;
        r_b_first <= (r_k == '0);
        r_b_last  <= a_last;
        r_c_first <= r_b_first;
        r_c_last  <= r_b_last;
        if (r_b_use) begin
            r_c_prod_l <= r_b_g * $signed(r_ring_q[2*SAMPLE_W-1:SAMPLE_W]);
            r_c_prod_r <= r_b_g * $signed(r_ring_q[SAMPLE_W-1:0]);
        end else begin
            r_c_prod_l <= '0;
            r_c_prod_r <= '0;
        end
        if (r_c_valid) begin
            r_acc_l <= (r_c_first ? '0 : r_acc_l) + {{BW{r_c_prod_l[PROD_W-1]}}, r_c_prod_l};
            r_acc_r <= (r_c_first ? '0 : r_acc_r) + {{BW{r_c_prod_r[PROD_W-1]}}, r_c_prod_r};
        end
    end

    always_comb begin
        rnd_l = r_acc_l + ROUND_HALF;
        rnd_r = r_acc_r + ROUND_HALF;
        q_l   = rnd_l[ACC_W-1:22];
        q_r   = rnd_r[ACC_W-1:22];
        sat_l = sat_q23(q_l);
        sat_r = sat_q23(q_r);
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (r_d_push) begin
            r_fifo_l[r_wr_ptr] <= sat_l;
            r_fifo_r[r_wr_ptr] <= sat_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_cred   <= '0;
        end else begin
            if (r_d_push) begin
                r_wr_ptr <= r_wr_ptr + RPW'(1);
            end
            if (out_pop) begin
                r_rd_ptr <= r_rd_ptr + RPW'(1);
            end
            r_fill <= r_fill + CW'(r_d_push) - CW'(out_pop);
            r_cred <= r_cred + CW'(in_acc && (i_kind == KIND_READ)) - CW'(out_pop);
        end
    end

    assign o_out_valid = (r_fill != '0);
    assign o_left_out  = r_fifo_l[r_rd_ptr];
    assign o_right_out = r_fifo_r[r_rd_ptr];

`ifndef NO_ASSERTIONS
    a_cred_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cred <= CW'(RES_DEPTH))
        else $error("outstanding read count beyond queue depth");

    a_fill_cred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_cred)
        else $error("queued frames exceed outstanding reads");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_push |-> (r_fill < CW'(RES_DEPTH)))
        else $error("frame pushed into a full queue");

    a_hold_mid_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_is_read && !a_last) |-> !o_in_ready)
        else $error("item taken while a read still walks its sources");

    a_one_ring_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(a_wr && a_use))
        else $error("ring written and read in the same cycle");
`endif

endmodule

@@ dv/tb_ring_send_matrix_mixer.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for ring_send_matrix_mixer: a directed table, then random slices of
// sample writes, gain changes and frame reads, all checked against a local mixing predictor.
// Depends on rsmm_pkg and the block's RTL.
module tb_ring_send_matrix_mixer;
    import rsmm_pkg::*;

    localparam int BUSES       = BUS_COUNT_DEF;
    localparam int RING        = RING_DEPTH_DEF;
    localparam int RING_BITS   = $clog2(RING);
    localparam int SETTLE      = BUS_COUNT_DEF + 8;
    localparam int LIMIT       = 400000;
    localparam int PHASE_ITEMS = 50;
    localparam int PHASES      = 7;

    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] smp_t;
    typedef logic signed [GAIN_W-1:0]   gain_t;

    typedef struct {
        logic [1:0]        kind;
        logic [1:0]        bus;
        logic [1:0]        peer;
        logic [TIME_W-1:0] t;
        logic [11:0]       idx;
        logic [12:0]       frames;
        smp_t              left;
        smp_t              right;
        gain_t             gain;
    } item_t;

    typedef struct {
        smp_t left;
        smp_t right;
    } frame_t;

    typedef struct {
        item_t it;
        bit    zero_frame;
    } row_t;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_in_valid       = 1'b0;
    logic                o_in_ready;
    logic [1:0]          i_kind           = '0;
    logic [1:0]          i_bus            = '0;
    logic [1:0]          i_peer_bus       = '0;
    logic [TIME_W-1:0]   i_slice_time     = '0;
    logic [11:0]         i_frame_index    = '0;
    logic [12:0]         i_slice_frames   = '0;
    smp_t                i_left_in        = '0;
    smp_t                i_right_in       = '0;
    gain_t               i_gain_in        = '0;
    logic                o_out_valid;
    logic                i_out_ready      = 1'b0;
    smp_t                o_left_out;
    smp_t                o_right_out;
    logic                i_cfg_valid      = 1'b0;
    logic                o_cfg_ready;
    logic [STEP_W-1:0]   i_cfg_glide_step = '0;

    logic [2*SAMPLE_W-1:0] ring_mem [BUSES][RING];
    bit                    written  [BUSES][RING];
    logic [TIME_W-1:0]     run_lo   [BUSES];
    logic [TIME_W-1:0]     run_hi   [BUSES];
    gain_t                 gain_want [BUSES][BUSES];
    gain_t                 gain_now  [BUSES][BUSES];
    logic [STEP_W-1:0]     glide;

    frame_t            frame_q [$];
    row_t              dir_rows [$];
    int                errors     = 0;
    int                cycles     = 0;
    int                stall_left = 0;
    bit                quiet      = 1'b0;
    logic [TIME_W-1:0] eng_t      = '0;
    int                span       = 4;

    ring_send_matrix_mixer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_bus            (i_bus),
        .i_peer_bus       (i_peer_bus),
        .i_slice_time     (i_slice_time),
        .i_frame_index    (i_frame_index),
        .i_slice_frames   (i_slice_frames),
        .i_left_in        (i_left_in),
        .i_right_in       (i_right_in),
        .i_gain_in        (i_gain_in),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_left_out       (o_left_out),
        .o_right_out      (o_right_out),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_glide_step (i_cfg_glide_step)
    );

    always #5 i_clk = ~i_clk;

    function automatic item_t mk(logic [1:0] kind, logic [1:0] bus, logic [1:0] peer,
                                 logic [TIME_W-1:0] t, logic [11:0] idx, logic [12:0] frames,
                                 smp_t left, smp_t right, gain_t gain);
        item_t it;
        it.kind   = kind;
        it.bus    = bus;
        it.peer   = peer;
        it.t      = t;
        it.idx    = idx;
        it.frames = frames;
        it.left   = left;
        it.right  = right;
        it.gain   = gain;
        return it;
    endfunction

    function automatic smp_t pick_sample();
        case ($urandom_range(0, 7))
            0: return smp_t'(24'h7FFFFF);
            1: return smp_t'(24'h800000);
            2: return '0;
            default: return smp_t'($urandom);
        endcase
    endfunction

    function automatic longint read_pos(item_t it);
        longint lt, lf, ln;
        lt = it.t;
        lf = it.frames;
        ln = it.idx;
        return lt - lf + ln;
    endfunction

    function automatic bit slot_used(int s, item_t it, longint p);
        longint lo;
        lo = run_lo[s];
        return run_hi[s] >= it.t && (run_hi[s] - it.t) <= TIME_W'(RING / 4)
               && p >= 0 && p >= lo;
    endfunction

    // true when a read would weight a ring entry that was never written
    function automatic bit touches_blank(item_t it);
        longint p;
        int s;
        if (it.kind != KIND_READ || it.bus >= BUSES || it.frames == 0)
            return 1'b0;
        p = read_pos(it);
        for (s = 0; s < BUSES; s++) begin
            if (s != it.bus && (gain_want[s][it.bus] != 0 || gain_now[s][it.bus] != 0)
                && slot_used(s, it, p) && !written[s][RING_BITS'(p)])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic smp_t clip24(longint acc);
        longint v;
        v = (acc + 64'sd2097152) >>> 22;
        if (v > 8388607)
            v = 8388607;
        else if (v < -8388608)
            v = -8388608;
        return smp_t'(v);
    endfunction

    task automatic mix_item(input item_t it, output bit has_frame, output frame_t fr);
        longint p, want, g, stp, acc_l, acc_r, sl, sr;
        logic [2*SAMPLE_W-1:0] word;
        int s;
        has_frame = 1'b0;
        fr.left   = '0;
        fr.right  = '0;
        if (it.kind == KIND_WRITE) begin
            if (it.bus < BUSES && it.frames != 0) begin
                if (it.idx == 0 && it.t != run_hi[it.bus])
                    run_lo[it.bus] = it.t;
                ring_mem[it.bus][RING_BITS'(it.t + it.idx)] = {it.left, it.right};
                written[it.bus][RING_BITS'(it.t + it.idx)]  = 1'b1;
                run_hi[it.bus] = it.t + TIME_W'(it.frames);
            end
        end else if (it.kind == KIND_GAIN) begin
            if (it.bus < BUSES && it.peer < BUSES)
                gain_want[it.bus][it.peer] = (it.bus == it.peer) ? gain_t'(0) : it.gain;
        end else if (it.kind == KIND_READ) begin
            has_frame = 1'b1;
            if (it.bus < BUSES && it.frames != 0) begin
                acc_l = 0;
                acc_r = 0;
                stp   = glide;
                p     = read_pos(it);
                for (s = 0; s < BUSES; s++) begin
                    if (s == it.bus)
                        continue;
                    want = gain_want[s][it.bus];
                    g    = gain_now[s][it.bus];
                    if (want == 0 && g == 0)
                        continue;
                    if (g < want)
                        g = (g + stp > want) ? want : g + stp;
                    else
                        g = (g - stp < want) ? want : g - stp;
                    gain_now[s][it.bus] = gain_t'(g);
                    if (!slot_used(s, it, p))
                        continue;
                    word  = ring_mem[s][RING_BITS'(p)];
                    sl    = $signed(word[2*SAMPLE_W-1:SAMPLE_W]);
                    sr    = $signed(word[SAMPLE_W-1:0]);
                    acc_l += g * sl;
                    acc_r += g * sr;
                end
                fr.left  = clip24(acc_l);
                fr.right = clip24(acc_r);
            end
        end
    endtask

    task automatic note_mismatch(input string what, input smp_t got, input smp_t want);
        $display("mismatch %s: got %0d, want %0d (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    task automatic push_item(input item_t it, input bit zero_frame);
        bit has_frame;
        frame_t fr;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_kind         = it.kind;
        i_bus          = it.bus;
        i_peer_bus     = it.peer;
        i_slice_time   = it.t;
        i_frame_index  = it.idx;
        i_slice_frames = it.frames;
        i_left_in      = it.left;
        i_right_in     = it.right;
        i_gain_in      = it.gain;
        i_in_valid     = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        mix_item(it, has_frame, fr);
        if (has_frame) begin
            if (zero_frame) begin
                fr.left  = '0;
                fr.right = '0;
            end
            frame_q.push_back(fr);
        end
    endtask

    task automatic offer(input item_t it, inout int tally);
        if (touches_blank(it))
            return;
        push_item(it, 1'b0);
        if (!(it.kind == KIND_SPARE || it.bus >= BUSES
              || (it.kind == KIND_WRITE && it.frames == 0)
              || (it.kind == KIND_GAIN && it.peer >= BUSES)))
            tally++;
    endtask

    task automatic set_glide(input logic [STEP_W-1:0] v);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (frame_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_glide_step = v;
        i_cfg_valid      = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        glide = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic row(input logic [1:0] kind, input logic [1:0] bus, input logic [1:0] peer,
                       input logic [TIME_W-1:0] t, input logic [11:0] idx,
                       input logic [12:0] frames, input smp_t left, input smp_t right,
                       input gain_t gain, input bit zero_frame);
        row_t r;
        r.it         = mk(kind, bus, peer, t, idx, frames, left, right, gain);
        r.zero_frame = zero_frame;
        dir_rows.push_back(r);
    endtask

    // one slice of engine time: gain changes, then reads of the previous slice and writes of
    // this one, in either order
    task automatic run_slice(inout int tally);
        item_t it;
        bit reads_first;
        int k, b, n;
        if ($urandom_range(0, 9) == 0)
            span = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
        if ($urandom_range(0, 11) == 0)
            eng_t = ($urandom_range(0, 2) == 0) ? 48'hFFFF_FFFF_FFFF - $urandom_range(0, 40)
                                                : TIME_W'({$urandom, $urandom});
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                it = mk(KIND_GAIN, 2'($urandom_range(0, 2)), 2'($urandom_range(0, 2)),
                        TIME_W'({$urandom, $urandom}), 12'($urandom), 13'($urandom),
                        smp_t'($urandom), smp_t'($urandom), pick_sample());
                offer(it, tally);
            end
        end
        reads_first = 1'($urandom_range(0, 1));
        for (k = 0; k < 2; k++) begin
            if ((k == 0) == reads_first) begin
                for (n = 0; n < span; n++) begin
                    it = mk(KIND_READ, 2'($urandom_range(0, 2)), 2'($urandom), eng_t,
                            12'(n), 13'(span), smp_t'($urandom), smp_t'($urandom),
                            gain_t'($urandom));
                    offer(it, tally);
                end
            end else begin
                for (b = 0; b < BUSES; b++) begin
                    if ($urandom_range(0, 5) != 0) begin
                        for (n = 0; n < span; n++) begin
                            it = mk(KIND_WRITE, 2'(b), 2'($urandom), eng_t, 12'(n), 13'(span),
                                    pick_sample(), pick_sample(), gain_t'($urandom));
                            offer(it, tally);
                        end
                    end
                end
            end
        end
        eng_t += TIME_W'(span);
    endtask

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready = 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left  = $urandom_range(1, 6) - 1;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_out
        frame_t want;
        cycles++;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_q.size() == 0) begin
                note_mismatch("frame with none pending", o_left_out, '0);
            end else begin
                want = frame_q.pop_front();
                if (o_left_out !== want.left)
                    note_mismatch("left_out", o_left_out, want.left);
                if (o_right_out !== want.right)
                    note_mismatch("right_out", o_right_out, want.right);
            end
        end
    end

    initial begin : stim
        logic [STEP_W-1:0] steps [PHASES];
        item_t it;
        int tally, ph, s, d;
        for (s = 0; s < BUSES; s++) begin
            run_lo[s] = '0;
            run_hi[s] = '0;
            for (d = 0; d < BUSES; d++) begin
                gain_want[s][d] = '0;
                gain_now[s][d]  = '0;
            end
        end
        glide    = GLIDE_RESET;
        steps[0] = GLIDE_RESET;
        steps[1] = 23'd4194304;
        steps[2] = 23'd1;
        steps[3] = 23'd0;
        steps[4] = 23'h7FFFFF;
        steps[5] = STEP_W'($urandom);
        steps[6] = GLIDE_RESET;

        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        row(KIND_READ,  0, 0, 48'd0,   12'd0, 13'd1, '0, '0, '0, 1'b1);
        row(KIND_READ,  3, 0, 48'd5,   12'd0, 13'd1, '0, '0, '0, 1'b1);
        row(KIND_READ,  1, 0, 48'd5,   12'd0, 13'd0, '0, '0, '0, 1'b1);
        row(KIND_SPARE, 1, 0, 48'd7,   12'd0, 13'd1, 24'sd5, 24'sd5, 24'sd5, 1'b0);
        row(KIND_WRITE, 3, 0, 48'd9,   12'd0, 13'd1, 24'sd9, 24'sd9, '0, 1'b0);
        row(KIND_WRITE, 1, 0, 48'd9,   12'd0, 13'd0, 24'sd9, 24'sd9, '0, 1'b0);
        row(KIND_GAIN,  3, 0, 48'd0,   12'd0, 13'd1, '0, '0, 24'sh7FFFFF, 1'b0);
        row(KIND_GAIN,  0, 3, 48'd0,   12'd0, 13'd1, '0, '0, 24'sh7FFFFF, 1'b0);
        row(KIND_GAIN,  0, 0, 48'd0,   12'd0, 13'd1, '0, '0, 24'sh7FFFFF, 1'b0);
        row(KIND_GAIN,  1, 0, 48'd0,   12'd0, 13'd1, '0, '0, 24'sh7FFFFF, 1'b0);
        row(KIND_GAIN,  2, 0, 48'd0,   12'd0, 13'd1, '0, '0, 24'sh800000, 1'b0);
        row(KIND_WRITE, 1, 0, 48'd100, 12'd0, 13'd2, 24'sh7FFFFF, 24'sh800000, '0, 1'b0);
        row(KIND_WRITE, 1, 0, 48'd100, 12'd1, 13'd2, 24'sh800000, 24'sh7FFFFF, '0, 1'b0);
        row(KIND_WRITE, 2, 0, 48'd100, 12'd0, 13'd2, 24'sh7FFFFF, 24'sh7FFFFF, '0, 1'b0);
        row(KIND_WRITE, 2, 0, 48'd100, 12'd1, 13'd2, 24'sh800000, 24'sh800000, '0, 1'b0);
        row(KIND_READ,  0, 0, 48'd102, 12'd0, 13'd2, '0, '0, '0, 1'b0);
        row(KIND_READ,  0, 0, 48'd102, 12'd1, 13'd2, '0, '0, '0, 1'b0);
        row(KIND_READ,  0, 0, 48'd101, 12'd3, 13'd3, '0, '0, '0, 1'b0);
        row(KIND_READ,  0, 0, 48'd2,   12'd0, 13'd4, '0, '0, '0, 1'b1);
        row(KIND_WRITE, 0, 0, 48'hFFFF_FFFF_FFFF, 12'd4095, 13'd8191, 24'sd1, -24'sd1, '0,
            1'b0);
        row(KIND_WRITE, 0, 0, 48'd0,   12'd0, 13'd1, 24'sd3, -24'sd3, '0, 1'b0);
        row(KIND_GAIN,  1, 0, 48'd0,   12'd0, 13'd1, '0, '0, '0, 1'b0);
        row(KIND_READ,  0, 0, 48'd102, 12'd0, 13'd2, '0, '0, '0, 1'b0);
        row(KIND_READ,  2, 0, 48'd1,   12'd0, 13'd1, '0, '0, '0, 1'b0);
        row(KIND_READ,  2, 0, 48'hFFFF_FFFF_FFFF, 12'd4095, 13'd8191, '0, '0, '0, 1'b0);
        foreach (dir_rows[i]) begin
            if (!touches_blank(dir_rows[i].it))
                push_item(dir_rows[i].it, dir_rows[i].zero_frame);
        end

        eng_t = 48'd1000;
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES - 1)
                quiet = 1'b1;
            if (ph > 0)
                set_glide(steps[ph]);
            tally = 0;
            while (tally < PHASE_ITEMS) begin
                if ($urandom_range(0, 6) == 0) begin
                    it = mk(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                            2'($urandom_range(0, 3)), TIME_W'({$urandom, $urandom}),
                            12'($urandom), 13'($urandom_range(0, 8191)), smp_t'($urandom),
                            smp_t'($urandom), gain_t'($urandom));
                    offer(it, tally);
                end else begin
                    run_slice(tally);
                end
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (frame_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/rsmm_pkg.sv
hdl/ring_send_matrix_mixer.sv
dv/tb_ring_send_matrix_mixer.sv
